>>> rtl/core/jddm_pkg.sv
// ============================================================================
// jddm_pkg: shared types and constants of the differential drive mixer
// Register indexes, the configuration record with its reset values and the
// sequencer states.
// ============================================================================
package jddm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FIELD_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_TOL = 3'd0,
    CFG_PIVOT_ZONE = 3'd1,
    CFG_ARC_RECIP  = 3'd2,
    CFG_CURVE_PX   = 3'd3,
    CFG_CURVE_PY   = 3'd4,
    CFG_SLEW_EN    = 3'd5,
    CFG_SLEW_STEP  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0] center_tol;
    logic [14:0] pivot_zone;
    logic [15:0] arc_recip;
    logic [1:0]  curve_px;
    logic [1:0]  curve_py;
    logic        slew_en;
    logic [14:0] slew_step;
  } jddm_cfg_t;

  localparam jddm_cfg_t CFG_RESET = '{
    center_tol: 15'd1638,
    pivot_zone: 15'd1638,
    arc_recip:  16'd16384,
    curve_px:   2'd2,
    curve_py:   2'd2,
    slew_en:    1'b0,
    slew_step:  15'd1638
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CURVE,
    ST_CURVE_WAIT,
    ST_MIX,
    ST_ATT_WAIT,
    ST_SCALE,
    ST_SCALE_WAIT,
    ST_SLEW
  } state_e;

endpackage

>>> rtl/core/jddm_in_if.sv
// ============================================================================
// jddm_in_if: joystick sample channel
// Valid/ready channel carrying one raw (x, y) sample.
// ============================================================================
interface jddm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] joy_x;
  logic signed [15:0] joy_y;

  modport source (output valid, output joy_x, output joy_y, input ready);
  modport sink   (input valid, input joy_x, input joy_y, output ready);
endinterface

>>> rtl/core/jddm_out_if.sv
// ============================================================================
// jddm_out_if: motor drive result channel
// Valid/ready channel carrying the curved axes and both motor drives.
// ============================================================================
interface jddm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] curved_x;
  logic signed [15:0] curved_y;
  logic signed [15:0] motor_left;
  logic signed [15:0] motor_right;

  modport source (output valid, output curved_x, output curved_y,
                  output motor_left, output motor_right, input ready);
  modport sink   (input valid, input curved_x, input curved_y,
                  input motor_left, input motor_right, output ready);
endinterface

>>> rtl/core/joystick_differential_drive_mixer.sv
// ============================================================================
// joystick_differential_drive_mixer: arcade-style differential drive mixer
// Clamp, deadband and curve one joystick sample, mix it into left and right
// motor targets (pivot or arc mode) and update the stored drives.
// ============================================================================
//
//  channel    dir  handshake               payload
//  ---------  ---  ----------------------  ----------------------------------
//  joy_in     in   valid / ready           joy_x, joy_y
//  drive_out  out  valid / ready           curved_x, curved_y, motor_left,
//                                          motor_right
//  cfg        in   cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
//  Each curve power above one (a power of 0 counts as 1) adds one multiply,
//  and arc mode with a nonzero curved x adds two (attenuation and scaling);
//  all go through the single shared multiplier, each product issued in one
//  state and consumed in the wait state after it.
//  joy_in is ready only while the sequencer is idle. A waiting result sits in
//  the output register, so the next sample is still taken; the sequencer only
//  holds at its last step while that register is full.
//  Reset clears both drives and loads the register defaults.
// ============================================================================
module joystick_differential_drive_mixer
  import jddm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  jddm_in_if.sink               joy_in,
  jddm_out_if.source            drive_out
);

  // magnitude of a clamped axis (at most one, that is 2**FRAC_BITS)
  localparam int unsigned AW = FRAC_BITS + 1;
  // signed curved value and stored drive, plus or minus one
  localparam int unsigned CW = FRAC_BITS + 2;
  // multiplier operands: A takes magnitudes or curved y, B also takes the
  // attenuation, which can reach one minus 65535
  localparam int unsigned MA = FRAC_BITS + 2;
  localparam int unsigned MB = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
  localparam int unsigned PW = MA + MB;
  // mix targets: pivot sums reach two, scaled reverse wheel reaches 49151
  localparam int unsigned TW = (FRAC_BITS + 3 > 18) ? FRAC_BITS + 3 : 18;
  // raw axis compare width (sign extended input against one)
  localparam int unsigned VW = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
  // threshold compare width
  localparam int unsigned XW = (AW > 15) ? AW : 15;

  localparam logic signed [VW-1:0] ONE_V =
    {{(VW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [MB-1:0] ONE_B =
    {{(MB-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [CW-1:0] ONE_C =
    {1'b0, 1'b1, {FRAC_BITS{1'b0}}};

  jddm_cfg_t cfg;

  jddm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  state_e state_d, state_q;

  logic [AW-1:0]        mx_d, mx_q, my_d, my_q;      // preprocessed magnitudes
  logic                 sx_d, sx_q, sy_d, sy_q;      // signs (y already negated)
  logic [AW-1:0]        r_d, r_q;                    // curve accumulator
  logic [1:0]           k_d, k_q;                    // multiplies left in curve
  logic                 axis_d, axis_q;              // 0: x, 1: y
  logic [AW-1:0]        cmx_d, cmx_q, cmy_d, cmy_q;  // curved magnitudes
  logic signed [CW-1:0] cx_d, cx_q, cy_d, cy_q;
  logic signed [MB-1:0] att_d, att_q;
  logic signed [TW-1:0] tl_d, tl_q, tr_d, tr_q;
  logic signed [CW-1:0] left_d, left_q, right_d, right_q;

  logic                 out_valid_d, out_valid_q;
  logic signed [15:0]   ocx_d, ocx_q, ocy_d, ocy_q, oml_d, oml_q, omr_d, omr_q;

  // --------------------------------------------------------------------------
  // Input preprocessing: clamp to plus or minus one, deadband, negate y
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] x_ext, y_ext, xc, yc, xa, ya;
  logic [AW-1:0]        x_mag, y_mag;

  always_comb begin
    x_ext = VW'(joy_in.joy_x);
    y_ext = VW'(joy_in.joy_y);
    if (x_ext > ONE_V) begin
      xc = ONE_V;
    end else if (x_ext < -ONE_V) begin
      xc = -ONE_V;
    end else begin
      xc = x_ext;
    end
    if (y_ext > ONE_V) begin
      yc = ONE_V;
    end else if (y_ext < -ONE_V) begin
      yc = -ONE_V;
    end else begin
      yc = y_ext;
    end
    xa = xc[VW-1] ? -xc : xc;
    ya = yc[VW-1] ? -yc : yc;
    x_mag = xa[AW-1:0];
    y_mag = ya[AW-1:0];
    if (XW'(x_mag) < XW'(cfg.center_tol)) begin
      x_mag = '0;
    end
    if (XW'(y_mag) < XW'(cfg.center_tol)) begin
      y_mag = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  logic                 mul_en;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod, prod_sh;

  jddm_mul #(
    .A_W (MA),
    .B_W (MB)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // every product is truncated toward minus infinity
  assign prod_sh = prod >>> FRAC_BITS;

  // --------------------------------------------------------------------------
  // Slew limit and saturation, one instance per side
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] left_nxt, right_nxt;

  jddm_slew #(
    .FRAC_BITS (FRAC_BITS),
    .TGT_W     (TW)
  ) u_slew_left (
    .target_i (tl_q),
    .stored_i (left_q),
    .en_i     (cfg.slew_en),
    .step_i   (cfg.slew_step),
    .next_o   (left_nxt)
  );

  jddm_slew #(
    .FRAC_BITS (FRAC_BITS),
    .TGT_W     (TW)
  ) u_slew_right (
    .target_i (tr_q),
    .stored_i (right_q),
    .en_i     (cfg.slew_en),
    .step_i   (cfg.slew_step),
    .next_o   (right_nxt)
  );

  // --------------------------------------------------------------------------
  // Next state and datapath
  // --------------------------------------------------------------------------
  logic                 in_fire, out_fire;
  logic [AW-1:0]        cur_mag;
  logic signed [CW-1:0] r_signed;

  assign in_fire  = joy_in.valid && joy_in.ready;
  assign out_fire = out_valid_q && drive_out.ready;

  always_comb begin
    state_d     = state_q;
    mx_d        = mx_q;
    my_d        = my_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    r_d         = r_q;
    k_d         = k_q;
    axis_d      = axis_q;
    cmx_d       = cmx_q;
    cmy_d       = cmy_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    att_d       = att_q;
    tl_d        = tl_q;
    tr_d        = tr_q;
    left_d      = left_q;
    right_d     = right_q;
    ocx_d       = ocx_q;
    ocy_d       = ocy_q;
    oml_d       = oml_q;
    omr_d       = omr_q;
    out_valid_d = out_valid_q && !out_fire;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    cur_mag  = axis_q ? my_q : mx_q;
    r_signed = $signed({1'b0, r_q});

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mx_d    = x_mag;
          my_d    = y_mag;
          sx_d    = xc[VW-1];
          sy_d    = !yc[VW-1];
          r_d     = x_mag;
          k_d     = (cfg.curve_px == 2'd0) ? 2'd0 : cfg.curve_px - 2'd1;
          axis_d  = 1'b0;
          state_d = ST_CURVE;
        end
      end

      ST_CURVE: begin
        if (k_q != 2'd0) begin
          // r <- (r * |v|) >> FRAC_BITS
          mul_en  = 1'b1;
          mul_a   = $signed({1'b0, r_q});
          mul_b   = MB'($signed({1'b0, cur_mag}));
          state_d = ST_CURVE_WAIT;
        end else if (!axis_q) begin
          cmx_d  = r_q;
          cx_d   = sx_q ? -r_signed : r_signed;
          r_d    = my_q;
          k_d    = (cfg.curve_py == 2'd0) ? 2'd0 : cfg.curve_py - 2'd1;
          axis_d = 1'b1;
        end else begin
          cmy_d   = r_q;
          cy_d    = sy_q ? -r_signed : r_signed;
          state_d = ST_MIX;
        end
      end

      ST_CURVE_WAIT: begin
        r_d     = prod_sh[AW-1:0];
        k_d     = k_q - 2'd1;
        state_d = ST_CURVE;
      end

      ST_MIX: begin
        if ((XW'(cmy_q) < XW'(cfg.pivot_zone)) && (XW'(cmx_q) > XW'(cfg.pivot_zone))) begin
          // pivot: spin in place around the center
          tl_d    = TW'(cy_q) + TW'(cx_q);
          tr_d    = TW'(cy_q) - TW'(cx_q);
          state_d = ST_SLEW;
        end else begin
          tl_d = TW'(cy_q);
          tr_d = TW'(cy_q);
          if (cmx_q == '0) begin
            state_d = ST_SLEW;
          end else begin
            mul_en  = 1'b1;
            mul_a   = $signed({1'b0, cmx_q});
            mul_b   = MB'($signed({1'b0, cfg.arc_recip}));
            state_d = ST_ATT_WAIT;
          end
        end
      end

      ST_ATT_WAIT: begin
        // may go negative: the inside wheel then reverses
        att_d   = ONE_B - prod_sh[MB-1:0];
        state_d = ST_SCALE;
      end

      ST_SCALE: begin
        mul_en  = 1'b1;
        mul_a   = cy_q;
        mul_b   = att_q;
        state_d = ST_SCALE_WAIT;
      end

      ST_SCALE_WAIT: begin
        // attenuate the wheel on the inside of the turn
        if (sx_q) begin
          tl_d = prod_sh[TW-1:0];
        end else begin
          tr_d = prod_sh[TW-1:0];
        end
        state_d = ST_SLEW;
      end

      ST_SLEW: begin
        // hold until the output register is free
        if (!out_valid_q || drive_out.ready) begin
          left_d      = left_nxt;
          right_d     = right_nxt;
          ocx_d       = 16'(cx_q);
          ocy_d       = 16'(cy_q);
          oml_d       = 16'(left_nxt);
          omr_d       = 16'(right_nxt);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      k_q         <= '0;
      axis_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      right_q     <= right_d;
      k_q         <= k_d;
      axis_q      <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q  <= mx_d;
    my_q  <= my_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    r_q   <= r_d;
    cmx_q <= cmx_d;
    cmy_q <= cmy_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    att_q <= att_d;
    tl_q  <= tl_d;
    tr_q  <= tr_d;
    ocx_q <= ocx_d;
    ocy_q <= ocy_d;
    oml_q <= oml_d;
    omr_q <= omr_d;
  end

  assign joy_in.ready          = (state_q == ST_IDLE);
  assign drive_out.valid       = out_valid_q;
  assign drive_out.curved_x    = ocx_q;
  assign drive_out.curved_y    = ocy_q;
  assign drive_out.motor_left  = oml_q;
  assign drive_out.motor_right = omr_q;

`ifndef ASSERT_OFF
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_SLEW)
    else $error("result raised without a drive update");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !joy_in.ready)
    else $error("sample taken while previous one in progress");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q <= ONE_C) && (left_q >= -ONE_C) &&
    (right_q <= ONE_C) && (right_q >= -ONE_C))
    else $error("stored drive outside plus or minus one");

  a_curve_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CURVE_WAIT) |-> (k_q != 2'd0))
    else $error("curve multiply issued with no power left");

  a_scale_needs_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE_WAIT) |-> (cmx_q != '0))
    else $error("inside wheel scaled with zero turn");
`endif

endmodule

>>> rtl/core/jddm_cfg.sv
// ============================================================================
// jddm_cfg: configuration register file
// Write-only registers, masked to their widths; unknown indexes are dropped.
// ============================================================================
module jddm_cfg
  import jddm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output jddm_cfg_t             cfg_o
);

  jddm_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_TOL: cfg_d.center_tol = cfg_wdata_i[14:0];
        CFG_PIVOT_ZONE: cfg_d.pivot_zone = cfg_wdata_i[14:0];
        CFG_ARC_RECIP:  cfg_d.arc_recip  = cfg_wdata_i;
        CFG_CURVE_PX:   cfg_d.curve_px   = cfg_wdata_i[1:0];
        CFG_CURVE_PY:   cfg_d.curve_py   = cfg_wdata_i[1:0];
        CFG_SLEW_EN:    cfg_d.slew_en    = cfg_wdata_i[0];
        CFG_SLEW_STEP:  cfg_d.slew_step  = cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/jddm_mul.sv
// ============================================================================
// jddm_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ============================================================================
module jddm_mul #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 18
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [A_W-1:0]     a_i,
  input  logic signed [B_W-1:0]     b_i,
  output logic signed [A_W+B_W-1:0] prod_o
);

  logic signed [A_W+B_W-1:0] prod_q;

  // capture only when the sequencer issues an operation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/core/jddm_slew.sv
// ============================================================================
// jddm_slew: drive rate limiter and saturation
// Step the stored drive toward its target when enabled (else take the target), then clamp to plus or minus one.
// ============================================================================
module jddm_slew #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned TGT_W     = 18
) (
  input  logic signed [TGT_W-1:0]     target_i,
  input  logic signed [FRAC_BITS+1:0] stored_i,
  input  logic                        en_i,
  input  logic [14:0]                 step_i,
  output logic signed [FRAC_BITS+1:0] next_o
);

  localparam int unsigned SW = TGT_W + 2;
  localparam int unsigned CW = FRAC_BITS + 2;
  localparam logic signed [SW-1:0] ONE_S =
    {{(SW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [SW-1:0] diff, lim, dclamp, nxt, sat;

  always_comb begin
    diff = SW'(target_i) - SW'(stored_i);
    lim  = $signed({{(SW-15){1'b0}}, step_i});
    if (diff > lim) begin
      dclamp = lim;
    end else if (diff < -lim) begin
      dclamp = -lim;
    end else begin
      dclamp = diff;
    end
    nxt = en_i ? (SW'(stored_i) + dclamp) : SW'(target_i);
    if (nxt > ONE_S) begin
      sat = ONE_S;
    end else if (nxt < -ONE_S) begin
      sat = -ONE_S;
    end else begin
      sat = nxt;
    end
    next_o = CW'(sat);
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for joystick_differential_drive_mixer
// Feeds joystick samples over the valid/ready input channel and predicts the
// curved axes and both motor drives of every sample. Each result on the output
// channel is checked against the oldest prediction. The registers are
// reprogrammed between phases, including extreme and oversized values, while
// both channel sides idle at random.
// ============================================================================
module testbench;
  import jddm_pkg::*;

  localparam int FRAC = 14;
  localparam longint UNIT = longint'(1) << FRAC;

  // Index past the end of the register list; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  // Directed samples: extremes of the raw range, full-scale corners, the
  // deadband edge, pure pivots, pure forward/reverse and mixed arc turns.
  localparam int CORNER_N = 21;
  localparam int CORNER_X [CORNER_N] = '{
    0, 32767, -32768, 16384, -16384, 0, 0, 16384, -16384, 1637, 1638,
    16384, -16384, 8000, -8000, 2000, 32767, -32768, 1, -1, 12000
  };
  localparam int CORNER_Y [CORNER_N] = '{
    0, 0, 0, 16384, -16384, -16384, 16384, 0, 0, 1637, -1638,
    -16384, -16384, -12000, 12000, -1000, -32768, 32767, -1, 1, -4000
  };

  // Raw values that sit on the clamp and deadband boundaries
  localparam int EDGE_N = 9;
  localparam int EDGE_VALS [EDGE_N] = '{
    -32768, 32767, -16384, 16384, 0, -16385, 16385, 1, -1
  };

  typedef struct packed {
    logic signed [15:0] jx;
    logic signed [15:0] jy;
  } joy_sample_t;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] ml;
    logic signed [15:0] mr;
  } drive_rec_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  jddm_in_if  joy_if ();
  jddm_out_if drv_if ();

  joystick_differential_drive_mixer #(
    .FRAC_BITS (FRAC)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .joy_in      (joy_if),
    .drive_out   (drv_if)
  );

  // Shadow copy of the register file and of the stored motor drives
  jddm_cfg_t shadow_cfg;
  longint    left_drive_q;
  longint    right_drive_q;

  joy_sample_t sample_backlog [$];
  drive_rec_t  predicted_drives [$];
  joy_sample_t last_sample;
  joy_sample_t drv_next;
  drive_rec_t  got_rec;
  drive_rec_t  want_rec;

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Sign-keeping response curve |v|^p; a power of zero acts as linear
  function automatic longint shape_axis(longint v, logic [1:0] pw);
    longint mag;
    longint r;
    int     n;
    int     i;
    mag = (v < 0) ? -v : v;
    r   = mag;
    n   = (pw == 2'd0) ? 1 : int'(pw);
    for (i = 1; i < n; i++) r = (r * mag) >>> FRAC;
    return (v < 0) ? -r : r;
  endfunction

  // Step a stored drive toward its target, then saturate to +-1.0
  function automatic longint step_drive(longint stored, longint target);
    longint nxt;
    longint lim;
    longint dlt;
    nxt = target;
    if (shadow_cfg.slew_en) begin
      lim = shadow_cfg.slew_step;
      dlt = target - stored;
      if (dlt > lim) dlt = lim;
      else if (dlt < -lim) dlt = -lim;
      nxt = stored + dlt;
    end
    if (nxt > UNIT) nxt = UNIT;
    else if (nxt < -UNIT) nxt = -UNIT;
    return nxt;
  endfunction

  // Work out one result and advance the shadow drives
  function automatic drive_rec_t mix_sample(logic signed [15:0] jx, logic signed [15:0] jy);
    drive_rec_t r;
    longint x;
    longint y;
    longint ct;
    longint pz;
    longint arc;
    longint cx;
    longint cy;
    longint ax;
    longint ay;
    longint att;
    longint tl;
    longint tr;
    ct  = shadow_cfg.center_tol;
    pz  = shadow_cfg.pivot_zone;
    arc = shadow_cfg.arc_recip;
    x = jx;
    y = jy;
    if (x > UNIT) x = UNIT; else if (x < -UNIT) x = -UNIT;
    if (y > UNIT) y = UNIT; else if (y < -UNIT) y = -UNIT;
    if (((x < 0) ? -x : x) < ct) x = 0;
    if (((y < 0) ? -y : y) < ct) y = 0;
    y  = -y;
    cx = shape_axis(x, shadow_cfg.curve_px);
    cy = shape_axis(y, shadow_cfg.curve_py);
    ax = (cx < 0) ? -cx : cx;
    ay = (cy < 0) ? -cy : cy;
    if (ay < pz && ax > pz) begin
      tl = cx + cy;
      tr = -cx + cy;
    end else begin
      // attenuation may go negative for arc_recip above 1.0: inside wheel reverses
      att = UNIT - ((ax * arc) >>> FRAC);
      tl  = cy;
      tr  = cy;
      if (cx < 0) tl = (cy * att) >>> FRAC;
      else if (cx > 0) tr = (cy * att) >>> FRAC;
    end
    left_drive_q  = step_drive(left_drive_q, tl);
    right_drive_q = step_drive(right_drive_q, tr);
    r.cx = cx[15:0];
    r.cy = cy[15:0];
    r.ml = left_drive_q[15:0];
    r.mr = right_drive_q[15:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present samples from the backlog, predict on every transaction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (joy_if.valid && joy_if.ready) begin
        predicted_drives.push_back(mix_sample(joy_if.joy_x, joy_if.joy_y));
      end
      // Advance only when nothing is on offer or the offer was just taken
      if (!joy_if.valid || joy_if.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_next     = sample_backlog.pop_front();
          joy_if.valid <= 1'b1;
          joy_if.joy_x <= drv_next.jx;
          joy_if.joy_y <= drv_next.jy;
        end else begin
          joy_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check every result transaction, stall the output at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (drv_if.valid && drv_if.ready) begin
        got_rec.cx = drv_if.curved_x;
        got_rec.cy = drv_if.curved_y;
        got_rec.ml = drv_if.motor_left;
        got_rec.mr = drv_if.motor_right;
        if (predicted_drives.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: result with no sample pending: cx=%0d cy=%0d l=%0d r=%0d",
                     got_rec.cx, got_rec.cy, got_rec.ml, got_rec.mr);
        end else begin
          want_rec = predicted_drives.pop_front();
          if (got_rec.cx !== want_rec.cx || got_rec.cy !== want_rec.cy ||
              got_rec.ml !== want_rec.ml || got_rec.mr !== want_rec.mr) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: want cx=%0d cy=%0d l=%0d r=%0d, got cx=%0d cy=%0d l=%0d r=%0d",
                       want_rec.cx, want_rec.cy, want_rec.ml, want_rec.mr,
                       got_rec.cx, got_rec.cy, got_rec.ml, got_rec.mr);
          end
        end
      end
      drv_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Write one register and mirror it, masked to its width, in the shadow copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_CENTER_TOL: shadow_cfg.center_tol = val[14:0];
      CFG_PIVOT_ZONE: shadow_cfg.pivot_zone = val[14:0];
      CFG_ARC_RECIP:  shadow_cfg.arc_recip  = val;
      CFG_CURVE_PX:   shadow_cfg.curve_px   = val[1:0];
      CFG_CURVE_PY:   shadow_cfg.curve_py   = val[1:0];
      CFG_SLEW_EN:    shadow_cfg.slew_en    = val[0];
      CFG_SLEW_STEP:  shadow_cfg.slew_step  = val[14:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [15:0] ct, input logic [15:0] pz,
                           input logic [15:0] ar, input logic [15:0] px,
                           input logic [15:0] py, input logic [15:0] se,
                           input logic [15:0] ss);
    write_reg(CFG_CENTER_TOL, ct);
    write_reg(CFG_PIVOT_ZONE, pz);
    write_reg(CFG_ARC_RECIP, ar);
    write_reg(CFG_CURVE_PX, px);
    write_reg(CFG_CURVE_PY, py);
    write_reg(CFG_SLEW_EN, se);
    write_reg(CFG_SLEW_STEP, ss);
    write_reg(CFG_IDX_SPARE, 16'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random registers, mostly in the useful range, sometimes oversized
  task automatic load_random_regs();
    logic [15:0] ct;
    logic [15:0] pz;
    ct = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
    pz = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
    load_regs(ct, pz, 16'($urandom), 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
              16'($urandom_range(0, 1)), 16'($urandom_range(0, 16384)));
  endtask

  function automatic joy_sample_t random_sample();
    joy_sample_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // hold the stick still so a slewed drive can settle
      s = last_sample;
    end else if (pick < 30) begin
      s.jx = 16'($urandom);
      s.jy = 16'($urandom);
    end else if (pick < 70) begin
      s.jx = 16'($urandom_range(0, 32768) - 16384);
      s.jy = 16'($urandom_range(0, 32768) - 16384);
    end else if (pick < 85) begin
      s.jx = 16'($urandom_range(0, 8000) - 4000);
      s.jy = 16'($urandom_range(0, 8000) - 4000);
    end else begin
      s.jx = 16'(EDGE_VALS[$urandom_range(0, EDGE_N - 1)]);
      s.jy = 16'(EDGE_VALS[$urandom_range(0, EDGE_N - 1)]);
    end
    last_sample = s;
    return s;
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) sample_backlog.push_back(random_sample());
  endtask

  // Wait until the backlog is sent and every pending result is back, then let the
  // sequencer settle before the registers change; sample on the falling edge
  // so the driver's update of the offer has landed
  task automatic drain();
    while (sample_backlog.size() != 0 || joy_if.valid || predicted_drives.size() != 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    joy_if.valid  = 1'b0;
    joy_if.joy_x  = '0;
    joy_if.joy_y  = '0;
    drv_if.ready  = 1'b0;
    shadow_cfg    = CFG_RESET;
    left_drive_q  = 0;
    right_drive_q = 0;
    last_sample   = '0;
    fail_count    = 0;
    send_idle_pct = 13;
    recv_idle_pct = 87;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed samples at the reset register values
    for (int i = 0; i < CORNER_N; i++)
      sample_backlog.push_back('{16'(CORNER_X[i]), 16'(CORNER_Y[i])});
    drain();

    // Linear curves, no deadband, no pivot zone
    load_regs(16'd0, 16'd0, 16'd16384, 16'd1, 16'd1, 16'd0, 16'd1638);
    queue_random(150);
    drain();

    // Extremes: full deadband and pivot zone, strongest arc reversal, cubic
    // curves, one-LSB slew steps
    load_regs(16'd16384, 16'd16384, 16'd65535, 16'd3, 16'd3, 16'd1, 16'd1);
    queue_random(80);
    drain();

    // Oversized writes: masked to zero deadband and top pivot zone; curve
    // power zero on x; slew enabled with a zero step so the drives freeze
    load_regs(16'h8000, 16'hFFFF, 16'd0, 16'h0004, 16'hFFFF, 16'h0003, 16'h8000);
    queue_random(80);
    drain();

    // Receiver mostly ready, sender mostly idle
    send_idle_pct = 87;
    recv_idle_pct = 13;
    load_regs(16'd1638, 16'd4000, 16'd40000, 16'd2, 16'd3, 16'd1, 16'd16384);
    queue_random(200);
    drain();
    for (int p = 0; p < 2; p++) begin
      load_random_regs();
      queue_random(130);
      drain();
    end

    // Back to back, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int p = 0; p < 4; p++) begin
      load_random_regs();
      queue_random(130);
      drain();
    end

    if (fail_count == 0 && predicted_drives.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/jddm_pkg.sv
rtl/core/jddm_in_if.sv
rtl/core/jddm_out_if.sv
rtl/core/jddm_cfg.sv
rtl/core/jddm_mul.sv
rtl/core/jddm_slew.sv
rtl/core/joystick_differential_drive_mixer.sv
tb/testbench.sv
